>>> rtl/bgpg_pkg.sv
`timescale 1ns / 1ps

package bgpg_pkg;

  // Field widths
  localparam int CP_W       = 21;
  localparam int COORD_W    = 12;
  localparam int COL_W      = 5;
  localparam int ROW_W      = 6;
  localparam int COLOR_W    = 32;
  localparam int CELL_W_W   = 6;
  localparam int CELL_H_W   = 7;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CELL_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CELL_HEIGHT = 1'd1;

  localparam logic [CELL_W_W-1:0] CELL_W_RESET = 6'd8;
  localparam logic [CELL_H_W-1:0] CELL_H_RESET = 7'd16;
  localparam int                  MIN_CELL_DIM = 4;

  // Code point ranges
  localparam logic [CP_W-1:0] CP_BOX_LO = 21'h2500;
  localparam logic [CP_W-1:0] CP_BOX_HI = 21'h257F;
  localparam logic [CP_W-1:0] CP_BLK_LO = 21'h2580;
  localparam logic [CP_W-1:0] CP_BLK_HI = 21'h259F;
  localparam logic [CP_W-1:0] CP_BRL_LO = 21'h2800;
  localparam logic [CP_W-1:0] CP_BRL_HI = 21'h28FF;

  // Box glyphs drawn outside the stroke table; the double cross is in it
  localparam logic [CP_W-1:0] CP_DASH_TRIPLE_H = 21'h2504;
  localparam logic [CP_W-1:0] CP_DASH_TRIPLE_V = 21'h2506;
  localparam logic [CP_W-1:0] CP_DASH_QUAD_H   = 21'h2508;
  localparam logic [CP_W-1:0] CP_DASH_DOUBLE_H = 21'h254C;
  localparam logic [CP_W-1:0] CP_DASH_DOUBLE_V = 21'h254E;
  localparam logic [CP_W-1:0] CP_DOUBLE_CROSS  = 21'h256C;
  localparam logic [CP_W-1:0] CP_ARC_DR        = 21'h256D;
  localparam logic [CP_W-1:0] CP_ARC_DL        = 21'h256E;
  localparam logic [CP_W-1:0] CP_ARC_UL        = 21'h256F;
  localparam logic [CP_W-1:0] CP_ARC_UR        = 21'h2570;
  localparam logic [CP_W-1:0] CP_DIAG_RISE     = 21'h2571;
  localparam logic [CP_W-1:0] CP_DIAG_FALL     = 21'h2572;
  localparam logic [CP_W-1:0] CP_DIAG_CROSS    = 21'h2573;

  // Block elements
  localparam logic [CP_W-1:0] CP_UPPER_HALF  = 21'h2580;
  localparam logic [CP_W-1:0] CP_LOWER_LO    = 21'h2581;
  localparam logic [CP_W-1:0] CP_LOWER_HI    = 21'h2587;
  localparam logic [CP_W-1:0] CP_FULL_BLOCK  = 21'h2588;
  localparam logic [CP_W-1:0] CP_LEFT_LO     = 21'h2589;
  localparam logic [CP_W-1:0] CP_LEFT_HI     = 21'h258F;
  localparam logic [CP_W-1:0] CP_LEFT_HALF   = 21'h258C;
  localparam logic [CP_W-1:0] CP_RIGHT_HALF  = 21'h2590;
  localparam logic [CP_W-1:0] CP_SHADE_LIGHT = 21'h2591;
  localparam logic [CP_W-1:0] CP_SHADE_MED   = 21'h2592;
  localparam logic [CP_W-1:0] CP_SHADE_DARK  = 21'h2593;
  localparam logic [CP_W-1:0] CP_QUAD_LL     = 21'h2596;
  localparam logic [CP_W-1:0] CP_QUAD_LR     = 21'h2597;
  localparam logic [CP_W-1:0] CP_QUAD_UL     = 21'h2598;
  localparam logic [CP_W-1:0] CP_QUAD_NOT_UR = 21'h2599;
  localparam logic [CP_W-1:0] CP_QUAD_UL_LR  = 21'h259A;
  localparam logic [CP_W-1:0] CP_QUAD_NOT_LR = 21'h259B;
  localparam logic [CP_W-1:0] CP_QUAD_NOT_LL = 21'h259C;
  localparam logic [CP_W-1:0] CP_QUAD_UR     = 21'h259D;
  localparam logic [CP_W-1:0] CP_QUAD_UR_LL  = 21'h259E;
  localparam logic [CP_W-1:0] CP_QUAD_NOT_UL = 21'h259F;

  // Stroke mask bits: single, heavy, double; left, right, top, bottom arms
  localparam logic [11:0] S_HL = 12'h001;
  localparam logic [11:0] S_HR = 12'h002;
  localparam logic [11:0] S_VT = 12'h004;
  localparam logic [11:0] S_VB = 12'h008;
  localparam logic [11:0] K_HL = 12'h010;
  localparam logic [11:0] K_HR = 12'h020;
  localparam logic [11:0] K_VT = 12'h040;
  localparam logic [11:0] K_VB = 12'h080;
  localparam logic [11:0] D_HL = 12'h100;
  localparam logic [11:0] D_HR = 12'h200;
  localparam logic [11:0] D_VT = 12'h400;
  localparam logic [11:0] D_VB = 12'h800;

  // Braille dot grid position per dot bit
  localparam logic       DOT_COL [8] = '{1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1};
  localparam logic [1:0] DOT_ROW [8] = '{2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2, 2'd3, 2'd3};

  typedef struct packed {
    logic [CP_W-1:0]    code_point;
    logic [COORD_W-1:0] cell_left;
    logic [COORD_W-1:0] cell_top;
    logic [COL_W-1:0]   column;
    logic [ROW_W-1:0]   row;
  } glyph_req_t;

  typedef struct packed {
    logic on;
    logic known;
  } eval_res_t;

  function automatic logic [11:0] box_mask(input logic [CP_W-1:0] cp);
    logic [11:0] m;
    m = 12'h000;
    case (cp)
      21'h2500: m = S_HL | S_HR;
      21'h2502: m = S_VT | S_VB;
      21'h2501: m = K_HL | K_HR;
      21'h2503: m = K_VT | K_VB;
      21'h250C: m = S_HR | S_VB;
      21'h2510: m = S_HL | S_VB;
      21'h2514: m = S_HR | S_VT;
      21'h2518: m = S_HL | S_VT;
      21'h251C: m = S_HR | S_VT | S_VB;
      21'h2524: m = S_HL | S_VT | S_VB;
      21'h252C: m = S_HL | S_HR | S_VB;
      21'h2534: m = S_HL | S_HR | S_VT;
      21'h253C: m = S_HL | S_HR | S_VT | S_VB;
      21'h250F: m = K_HR | K_VB;
      21'h2513: m = K_HL | K_VB;
      21'h2517: m = K_HR | K_VT;
      21'h251B: m = K_HL | K_VT;
      21'h2523: m = K_HR | K_VT | K_VB;
      21'h252B: m = K_HL | K_VT | K_VB;
      21'h2533: m = K_HL | K_HR | K_VB;
      21'h253B: m = K_HL | K_HR | K_VT;
      21'h254B: m = K_HL | K_HR | K_VT | K_VB;
      21'h251D: m = K_HR | S_VT | S_VB;
      21'h2525: m = K_HL | S_VT | S_VB;
      21'h252F: m = S_HL | S_HR | K_VB;
      21'h2537: m = S_HL | S_HR | K_VT;
      21'h253F: m = S_HL | S_HR | K_VT | K_VB;
      21'h2542: m = K_HL | K_HR | S_VT | S_VB;
      21'h2550: m = D_HL | D_HR;
      21'h2551: m = D_VT | D_VB;
      21'h2554: m = D_HR | D_VB;
      21'h2557: m = D_HL | D_VB;
      21'h255A: m = D_HR | D_VT;
      21'h255D: m = D_HL | D_VT;
      21'h2560: m = D_HR | D_VT | D_VB;
      21'h2563: m = D_HL | D_VT | D_VB;
      21'h2566: m = D_HL | D_HR | D_VB;
      21'h2569: m = D_HL | D_HR | D_VT;
      21'h256C: m = D_HL | D_HR | D_VT | D_VB;
      default:  m = 12'h000;
    endcase
    return m;
  endfunction

endpackage

>>> rtl/bgpg_in_if.sv
`timescale 1ns / 1ps

interface bgpg_in_if;
  logic        valid;
  logic        ready;
  logic [20:0] code_point;
  logic [11:0] cell_left;
  logic [11:0] cell_top;
  logic [4:0]  column;
  logic [5:0]  row;
  logic [31:0] fg_color;
  logic [31:0] bg_color;

  modport source (
    output valid, code_point, cell_left, cell_top, column, row, fg_color, bg_color,
    input  ready
  );
  modport sink (
    input  valid, code_point, cell_left, cell_top, column, row, fg_color, bg_color,
    output ready
  );
endinterface

>>> rtl/bgpg_out_if.sv
`timescale 1ns / 1ps

interface bgpg_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] pixel_color;
  logic        is_foreground;
  logic        glyph_known;

  modport source (
    output valid, pixel_color, is_foreground, glyph_known,
    input  ready
  );
  modport sink (
    input  valid, pixel_color, is_foreground, glyph_known,
    output ready
  );
endinterface

>>> rtl/bgpg_pixel_eval.sv
`timescale 1ns / 1ps

module bgpg_pixel_eval import bgpg_pkg::*; (
  input  glyph_req_t          req,
  input  logic [CELL_W_W-1:0] cell_w,
  input  logic [CELL_H_W-1:0] cell_h,
  output eval_res_t           res
);

  logic [CP_W-1:0] cp;
  logic [7:0] x, y, w, h, cx, cy;

  assign cp = req.code_point;
  assign x  = {3'b000, req.column};
  assign y  = {2'b00, req.row};
  assign w  = {2'b00, cell_w};
  assign h  = {1'b0, cell_h};
  assign cx = w >> 1;
  assign cy = h >> 1;

  // ---------------- stroke table glyphs ----------------
  logic [11:0] mask, arm_hit;
  logic arm_l, arm_r, arm_t, arm_b;
  logic ty, ky, dy, tx, kx, dx;
  logic seg_on, cross_gap;

  assign mask  = box_mask(cp);
  assign arm_l = x <= cx;
  assign arm_r = (x >= cx) && (x < w);
  assign arm_t = y <= cy;
  assign arm_b = (y >= cy) && (y < h);
  assign ty    = y == cy;
  assign ky    = ty || (y == cy + 8'd1);
  assign dy    = (y == cy - 8'd1) || (y == cy + 8'd1);
  assign tx    = x == cx;
  assign kx    = tx || (x == cx + 8'd1);
  assign dx    = (x == cx - 8'd1) || (x == cx + 8'd1);

  assign arm_hit = {arm_b && dx, arm_t && dx, arm_r && dy, arm_l && dy,
                    arm_b && kx, arm_t && kx, arm_r && ky, arm_l && ky,
                    arm_b && tx, arm_t && tx, arm_r && ty, arm_l && ty};

  // double cross opens the four pixels around the center
  assign cross_gap = (cp == CP_DOUBLE_CROSS) && ((tx && dy) || (ty && dx));
  assign seg_on    = (|(mask & arm_hit)) && !cross_gap;

  // ---------------- dash thresholds ----------------
  logic [9:0]  w_x3, h_x3;
  logic [15:0] w_t1, h_t1;
  logic [16:0] w_t2, h_t2;
  logic [7:0]  w4, w34, w8, w3, w23, h4, h34, h3, h23;

  assign w_x3 = {2'b00, w} + {1'b0, w, 1'b0};
  assign h_x3 = {2'b00, h} + {1'b0, h, 1'b0};
  assign w4   = w >> 2;
  assign w8   = w >> 3;
  assign w34  = w_x3[9:2];
  assign h4   = h >> 2;
  assign h34  = h_x3[9:2];
  // divide by three: times 171, drop 9 bits (exact below 512)
  assign w_t1 = {8'h00, w} * 16'd171;
  assign h_t1 = {8'h00, h} * 16'd171;
  assign w_t2 = {8'h00, w, 1'b0} * 17'd171;
  assign h_t2 = {8'h00, h, 1'b0} * 17'd171;
  assign w3   = {1'b0, w_t1[15:9]};
  assign h3   = {1'b0, h_t1[15:9]};
  assign w23  = w_t2[16:9];
  assign h23  = h_t2[16:9];

  // ---------------- diagonals by cross-multiplication ----------------
  logic [7:0]  w1, h1, xm;
  logic [15:0] py, px, pxm;
  logic        diag_fall, diag_rise;

  assign w1  = w - 8'd1;
  assign h1  = h - 8'd1;
  assign xm  = w1 - x;
  assign py  = {8'h00, y} * {8'h00, w1};
  assign px  = {8'h00, x} * {8'h00, h1};
  assign pxm = {8'h00, xm} * {8'h00, h1};
  // x == floor(y*(w-1)/(h-1))  <=>  x*(h-1) <= y*(w-1) < (x+1)*(h-1)
  assign diag_fall = (px <= py) && (py < px + {8'h00, h1});
  assign diag_rise = (pxm <= py) && (py < pxm + {8'h00, h1});

  logic sp_on, sp_known;

  always_comb begin
    sp_on    = 1'b0;
    sp_known = 1'b1;
    case (cp)
      CP_DASH_TRIPLE_H: sp_on = ty && ((x < w4) || ((x >= cx) && (x < w34)) ||
                                       ((x >= w34) && (x < w)));
      CP_DASH_DOUBLE_H: sp_on = ty && ((x < w3) || ((x >= w23) && (x < w)));
      CP_DASH_QUAD_H:   sp_on = ty && ((x == w8) || (x == w4 + w8) ||
                                       (x == cx + w8) || (x == w34 + w8));
      CP_DASH_TRIPLE_V: sp_on = tx && ((y < h4) || ((y >= cy) && (y < h34)) ||
                                       ((y >= h34) && (y < h)));
      CP_DASH_DOUBLE_V: sp_on = tx && ((y < h3) || ((y >= h23) && (y < h)));
      CP_ARC_DR:        sp_on = (ty && (x > cx) && (x < w)) || (tx && (y > cy) && (y < h));
      CP_ARC_DL:        sp_on = (ty && (x < cx)) || (tx && (y > cy) && (y < h));
      CP_ARC_UR:        sp_on = (ty && (x > cx) && (x < w)) || (tx && (y < cy));
      CP_ARC_UL:        sp_on = (ty && (x < cx)) || (tx && (y < cy));
      CP_DIAG_RISE:     sp_on = diag_rise;
      CP_DIAG_FALL:     sp_on = diag_fall;
      CP_DIAG_CROSS:    sp_on = diag_fall || diag_rise;
      default:          sp_known = 1'b0;
    endcase
  end

  logic box_on, box_known;
  assign box_known = (mask != 12'h000) || sp_known;
  assign box_on    = (mask != 12'h000) ? seg_on : sp_on;

  // ---------------- block elements ----------------
  logic [3:0]  eighths;
  logic [11:0] frac_h, frac_w;
  logic        q_ul, q_ur, q_ll, q_lr;
  logic [1:0]  parity;
  logic        blk_on, blk_known;

  assign eighths = 4'd8 - {1'b0, cp[2:0]};
  assign frac_h  = {8'h00, eighths} * {4'h0, h};
  assign frac_w  = {8'h00, eighths} * {4'h0, w};
  assign q_ul    = (x < cx) && (y < cy);
  assign q_ur    = (x >= cx) && (y < cy);
  assign q_ll    = (x < cx) && (y >= cy);
  assign q_lr    = (x >= cx) && (y >= cy);
  // absolute x + y, low two bits
  assign parity  = req.cell_left[1:0] + req.cell_top[1:0] + req.column[1:0] + req.row[1:0];

  always_comb begin
    blk_on    = 1'b0;
    blk_known = 1'b1;
    if ((cp >= CP_LOWER_LO) && (cp <= CP_LOWER_HI)) begin
      blk_on = {1'b0, y} >= frac_h[11:3];
    end else if ((cp >= CP_LEFT_LO) && (cp <= CP_LEFT_HI) && (cp != CP_LEFT_HALF)) begin
      blk_on = {1'b0, x} <= frac_w[11:3];
    end else begin
      case (cp)
        CP_UPPER_HALF:  blk_on = y < cy;
        CP_FULL_BLOCK:  blk_on = 1'b1;
        CP_LEFT_HALF:   blk_on = x < cx;
        CP_RIGHT_HALF:  blk_on = x >= cx;
        CP_SHADE_LIGHT,
        CP_SHADE_MED:   blk_on = !parity[0];
        CP_SHADE_DARK:  blk_on = parity != 2'd3;
        CP_QUAD_LL:     blk_on = q_ll;
        CP_QUAD_LR:     blk_on = q_lr;
        CP_QUAD_UL:     blk_on = q_ul;
        CP_QUAD_UR:     blk_on = q_ur;
        CP_QUAD_NOT_UR: blk_on = !q_ur;
        CP_QUAD_UL_LR:  blk_on = q_ul || q_lr;
        CP_QUAD_NOT_LR: blk_on = !q_lr;
        CP_QUAD_NOT_LL: blk_on = !q_ll;
        CP_QUAD_UR_LL:  blk_on = q_ur || q_ll;
        CP_QUAD_NOT_UL: blk_on = !q_ul;
        default:        blk_known = 1'b0;
      endcase
    end
  end

  // ---------------- braille ----------------
  logic [7:0] dot_w, dot_h;
  logic [8:0] rad, x9, y9;
  logic [8:0] dot_x [8];
  logic [8:0] dot_y [8];
  logic [7:0] dot_hit;
  logic       brl_on;

  assign dot_w = w >> 1;
  assign dot_h = h >> 2;
  assign rad   = (dot_w > 8'd2) ? 9'd1 : 9'd0;
  assign x9    = {1'b0, x};
  assign y9    = {1'b0, y};

  for (genvar d = 0; d < 8; d++) begin : g_dot
    assign dot_x[d] = (DOT_COL[d] ? {1'b0, dot_w} : 9'd0) + {2'b00, dot_w[7:1]};
    assign dot_y[d] = 9'(DOT_ROW[d]) * {1'b0, dot_h} + {2'b00, dot_h[7:1]};
    assign dot_hit[d] = cp[d] &&
                        (x9 + rad >= dot_x[d]) && (x9 <= dot_x[d] + rad) &&
                        (y9 + rad >= dot_y[d]) && (y9 <= dot_y[d] + rad);
  end
  assign brl_on = |dot_hit;

  // ---------------- select ----------------
  logic in_box, in_blk, in_brl, in_cell;

  assign in_box  = (cp >= CP_BOX_LO) && (cp <= CP_BOX_HI);
  assign in_blk  = (cp >= CP_BLK_LO) && (cp <= CP_BLK_HI);
  assign in_brl  = (cp >= CP_BRL_LO) && (cp <= CP_BRL_HI);
  assign in_cell = (x < w) && (y < h);

  always_comb begin
    if (in_box) begin
      res.known = box_known;
      res.on    = box_on;
    end else if (in_blk) begin
      res.known = blk_known;
      res.on    = blk_on;
    end else if (in_brl) begin
      res.known = 1'b1;
      res.on    = brl_on;
    end else begin
      res.known = 1'b0;
      res.on    = 1'b0;
    end
    res.on = res.on && in_cell;
  end

endmodule

>>> rtl/box_glyph_pixel_generator.sv
`timescale 1ns / 1ps

// A request is taken into the input register, then passes to the result register.
// Throughput: one request per clock while the sink is ready, set by the register pair.
// The whole glyph test is one combinational pass between those two registers.
// Reset (rst_n low, synchronous): both stages empty, cell size back to 8 x 16.

module box_glyph_pixel_generator import bgpg_pkg::*; #(
  parameter int MAX_CELL_WIDTH  = 32,
  parameter int MAX_CELL_HEIGHT = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  bgpg_in_if.sink               in_if,
  bgpg_out_if.source            out_if,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  // ---------------- configuration registers ----------------
  logic [CELL_W_W-1:0] cell_width_r, cell_width_nxt;
  logic [CELL_H_W-1:0] cell_height_r, cell_height_nxt;

  always_comb begin
    cell_width_nxt  = cell_width_r;
    cell_height_nxt = cell_height_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_CELL_WIDTH:  cell_width_nxt  = cfg_wdata[CELL_W_W-1:0];
        CFG_CELL_HEIGHT: cell_height_nxt = cfg_wdata[CELL_H_W-1:0];
        default: ;  // index beyond the list: dropped
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_width_r  <= CELL_W_RESET;
      cell_height_r <= CELL_H_RESET;
    end else begin
      cell_width_r  <= cell_width_nxt;
      cell_height_r <= cell_height_nxt;
    end
  end

  // Saturate the programmed size into the supported range before use.
  localparam logic [CELL_W_W:0] MAX_W = (CELL_W_W + 1)'(MAX_CELL_WIDTH);
  localparam logic [CELL_H_W:0] MAX_H = (CELL_H_W + 1)'(MAX_CELL_HEIGHT);
  localparam logic [CELL_W_W-1:0] MIN_W = CELL_W_W'(MIN_CELL_DIM);
  localparam logic [CELL_H_W-1:0] MIN_H = CELL_H_W'(MIN_CELL_DIM);

  logic [CELL_W_W-1:0] cell_w;
  logic [CELL_H_W-1:0] cell_h;

  always_comb begin
    if (cell_width_r < MIN_W) begin
      cell_w = MIN_W;
    end else if ({1'b0, cell_width_r} > MAX_W) begin
      cell_w = MAX_W[CELL_W_W-1:0];
    end else begin
      cell_w = cell_width_r;
    end
    if (cell_height_r < MIN_H) begin
      cell_h = MIN_H;
    end else if ({1'b0, cell_height_r} > MAX_H) begin
      cell_h = MAX_H[CELL_H_W-1:0];
    end else begin
      cell_h = cell_height_r;
    end
  end

  // ---------------- pipeline control ----------------
  // Input stage loads whenever it is empty or its content moves on; result
  // stage loads whenever it is empty or being taken. Both may hold a request
  // while the sink stalls; the source stalls only when both are full and the
  // sink is not ready.
  logic s1_v_r, s1_v_nxt;
  logic out_v_r, out_v_nxt;
  logic s1_load, out_load;

  assign out_load    = !out_v_r || out_if.ready;
  assign s1_load     = !s1_v_r || out_load;
  assign in_if.ready = s1_load;

  assign s1_v_nxt  = s1_load ? in_if.valid : s1_v_r;
  assign out_v_nxt = out_load ? s1_v_r : out_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  // ---------------- input register ----------------
  glyph_req_t         s1_req_r;
  logic [COLOR_W-1:0] s1_fg_r, s1_bg_r;

  always_ff @(posedge clk) begin
    if (s1_load && in_if.valid) begin
      s1_req_r.code_point <= in_if.code_point;
      s1_req_r.cell_left  <= in_if.cell_left;
      s1_req_r.cell_top   <= in_if.cell_top;
      s1_req_r.column     <= in_if.column;
      s1_req_r.row        <= in_if.row;
      s1_fg_r             <= in_if.fg_color;
      s1_bg_r             <= in_if.bg_color;
    end
  end

  // ---------------- glyph evaluation ----------------
  eval_res_t eval_res;

  bgpg_pixel_eval u_eval (
    .req    (s1_req_r),
    .cell_w (cell_w),
    .cell_h (cell_h),
    .res    (eval_res)
  );

  // ---------------- result register ----------------
  logic [COLOR_W-1:0] pix_color_r;
  logic               is_fg_r;
  logic               known_r;

  always_ff @(posedge clk) begin
    if (out_load && s1_v_r) begin
      pix_color_r <= eval_res.on ? s1_fg_r : s1_bg_r;
      is_fg_r     <= eval_res.on;
      known_r     <= eval_res.known;
    end
  end

  assign out_if.valid         = out_v_r;
  assign out_if.pixel_color   = pix_color_r;
  assign out_if.is_foreground = is_fg_r;
  assign out_if.glyph_known   = known_r;

  // ---------------- assertions ----------------
  // A drawn pixel always belongs to a known glyph.
  a_fg_needs_known: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && is_fg_r |-> known_r)
    else $error("foreground pixel reported for an unknown glyph");

  // Both stages full and the sink stalled: no new request may enter.
  a_full_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r && out_v_r && !out_if.ready |-> !in_if.ready)
    else $error("input accepted with both stages full");

  // A request in the input stage moves to the result stage when allowed.
  a_stage_advance: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r && out_load |=> out_v_r)
    else $error("request lost between stages");

  // Pixels outside the cell are always background.
  a_outside_is_bg: assert property (@(posedge clk) disable iff (!rst_n)
    s1_v_r && out_load &&
    (({1'b0, s1_req_r.column} >= cell_w) || ({1'b0, s1_req_r.row} >= cell_h))
    |=> !is_fg_r)
    else $error("foreground outside the cell");

endmodule
